/* hw/rtl/sh1_pkg.sv */
// Shared types, constants and helper functions of the SHA-1 message hasher.
// Used by sh1_core, sh1_feed and sha1_message_hasher_top; depends on nothing.
package sh1_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned AddrW       = $clog2(BlockWords);
  localparam int unsigned Rounds      = 80;
  localparam int unsigned RoundW      = $clog2(Rounds);
  localparam int unsigned LenW        = 61;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned DigIdxW     = 3;

  localparam logic [RoundW-1:0]  LastRound   = RoundW'(Rounds - 1);
  localparam logic [RoundW-1:0]  FirstSched  = RoundW'(BlockWords);
  localparam logic [AddrW-1:0]   LastSlot    = AddrW'(BlockWords - 1);
  localparam logic [AddrW-1:0]   LenHiSlot   = AddrW'(BlockWords - 2);
  localparam logic [DigIdxW-1:0] LastDigIdx  = DigIdxW'(DigestWords - 1);
  localparam logic [2:0]         FullBytes   = 3'd4;
  localparam logic [WordW-1:0]   PadMarker   = 32'h8000_0000;

  // round constants per 20-round stage
  localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

  // initial chaining values, element 0 is H0
  localparam logic [DigestWords-1:0][WordW-1:0] ShaIv = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  typedef logic [DigestWords-1:0][WordW-1:0] digest_t;

  // command bundle from the input sequencer to the round engine
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [WordW-1:0] wr_data;
    logic             start;
    logic             init;
  } core_cmd_t;

  // round function plus round constant
  function automatic logic [WordW-1:0] round_fk(input logic [RoundW-1:0] rnd,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c,
                                                input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    logic [WordW-1:0] k;
    if (rnd < RoundW'(20)) begin
      f = d ^ (b & (c ^ d));
      k = K0;
    end else if (rnd < RoundW'(40)) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < RoundW'(60)) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    return f + k;
  endfunction

  // final partial word: keep the valid leading bytes, append the 0x80 marker
  function automatic logic [WordW-1:0] pad_partial(input logic [WordW-1:0] data,
                                                   input logic [1:0] nbytes);
    logic [WordW-1:0] res;
    case (nbytes)
      2'd0:    res = 32'h8000_0000;
      2'd1:    res = {data[31:24], 24'h80_0000};
      2'd2:    res = {data[31:16], 16'h8000};
      2'd3:    res = {data[31:8], 8'h80};
      default: res = 32'h8000_0000;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/sh1_core.sv */
// Round engine: message schedule memories, working variables, chaining values.
// Depends on sh1_pkg.
module sh1_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sh1_pkg::core_cmd_t cmd_i,
  output logic              done_o,
  output sh1_pkg::digest_t  hash_o
);

  localparam logic [1:0] CIdle  = 2'd0;
  localparam logic [1:0] CPrep  = 2'd1;
  localparam logic [1:0] CRun   = 2'd2;
  localparam logic [1:0] CFinal = 2'd3;

  logic [1:0] state_q, state_d;
  logic [sh1_pkg::RoundW-1:0] rnd_q, rnd_d;
  sh1_pkg::digest_t h_q, h_d;
  logic [sh1_pkg::WordW-1:0] a_q, b_q, c_q, d_q, e_q;

  // two copies of the 16-word schedule, each with two read ports
  logic [sh1_pkg::WordW-1:0] mem_a [sh1_pkg::BlockWords];
  logic [sh1_pkg::WordW-1:0] mem_b [sh1_pkg::BlockWords];
  logic [sh1_pkg::WordW-1:0] ra0_q, ra1_q, rb0_q, rb1_q;

  logic [sh1_pkg::AddrW-1:0] nxt_slot;
  logic                      sched_we;
  logic                      wr_en;
  logic [sh1_pkg::AddrW-1:0] wr_addr;
  logic [sh1_pkg::WordW-1:0] wr_data;
  logic [sh1_pkg::WordW-1:0] w_sched, w_t, tmp;

  // reads for the coming round: w[t-16], w[t-14], w[t-8], w[t-3]
  assign nxt_slot = (state_q == CRun) ? rnd_q[sh1_pkg::AddrW-1:0] + 1'b1 : '0;

  always_ff @(posedge clk_i) begin
    ra0_q <= mem_a[nxt_slot];
    ra1_q <= mem_a[nxt_slot + sh1_pkg::AddrW'(2)];
    rb0_q <= mem_b[nxt_slot + sh1_pkg::AddrW'(8)];
    rb1_q <= mem_b[nxt_slot + sh1_pkg::AddrW'(13)];
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
  end

  assign w_sched = {ra0_q[30:0] ^ ra1_q[30:0] ^ rb0_q[30:0] ^ rb1_q[30:0],
                    ra0_q[31] ^ ra1_q[31] ^ rb0_q[31] ^ rb1_q[31]};
  assign w_t     = (rnd_q < sh1_pkg::FirstSched) ? ra0_q : w_sched;
  assign tmp     = {a_q[26:0], a_q[31:27]} + sh1_pkg::round_fk(rnd_q, b_q, c_q, d_q)
                   + e_q + w_t;

  // the engine owns the write port while expanding the schedule
  assign sched_we = (state_q == CRun) && (rnd_q >= sh1_pkg::FirstSched);
  assign wr_en    = sched_we | cmd_i.wr_en;
  assign wr_addr  = sched_we ? rnd_q[sh1_pkg::AddrW-1:0] : cmd_i.wr_addr;
  assign wr_data  = sched_we ? w_sched : cmd_i.wr_data;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    h_d     = h_q;
    case (state_q)
      CIdle: begin
        if (cmd_i.init) h_d = sh1_pkg::ShaIv;
        if (cmd_i.start) state_d = CPrep;
      end
      CPrep: begin
        rnd_d   = '0;
        state_d = CRun;
      end
      CRun: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == sh1_pkg::LastRound) state_d = CFinal;
      end
      CFinal: begin
        h_d[0]  = h_q[0] + a_q;
        h_d[1]  = h_q[1] + b_q;
        h_d[2]  = h_q[2] + c_q;
        h_d[3]  = h_q[3] + d_q;
        h_d[4]  = h_q[4] + e_q;
        state_d = CIdle;
      end
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      rnd_q   <= '0;
      h_q     <= sh1_pkg::ShaIv;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CPrep) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == CRun) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  assign done_o = (state_q == CFinal);
  assign hash_o = h_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> state_q == CIdle)
    else $error("compression started while engine busy");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> state_q == CIdle)
    else $error("block word written while engine busy");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CRun && rnd_q == sh1_pkg::LastRound) |=> state_q == CFinal)
    else $error("round 79 not followed by chaining update");

  a_init_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init |-> state_q == CIdle && !cmd_i.start)
    else $error("chaining reset overlaps a compression");

endmodule

/* hw/rtl/sh1_feed.sv */
// Input sequencer: packs words, counts length, pads, drives digest output.
// Depends on sh1_pkg; commands sh1_core.
module sh1_feed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sh1_pkg::WordW-1:0]    data_word_i,
  input  logic [2:0]                   byte_count_i,
  input  logic                         last_word_i,
  input  logic                         core_done_i,
  output sh1_pkg::core_cmd_t           cmd_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sh1_pkg::DigIdxW-1:0]  out_idx_o,
  output logic                         out_last_o
);

  localparam logic [2:0] FIdle  = 3'd0;
  localparam logic [2:0] FWait  = 3'd1;
  localparam logic [2:0] FMark  = 3'd2;
  localparam logic [2:0] FPad   = 3'd3;
  localparam logic [2:0] FLenLo = 3'd4;
  localparam logic [2:0] FOut   = 3'd5;

  logic [2:0] state_q, state_d, ret_q, ret_d;
  logic [sh1_pkg::AddrW-1:0] fill_q, fill_d;
  logic [sh1_pkg::LenW-1:0] len_q, len_d;
  logic [sh1_pkg::DigIdxW-1:0] idx_q, idx_d;

  logic                      push;
  logic [sh1_pkg::WordW-1:0] push_word;
  logic [2:0]                after;
  logic [2:0]                cnt_eff;

  assign cnt_eff = (byte_count_i > sh1_pkg::FullBytes) ? sh1_pkg::FullBytes : byte_count_i;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    fill_d    = fill_q;
    len_d     = len_q;
    idx_d     = idx_q;
    push      = 1'b0;
    push_word = '0;
    after     = state_q;
    cmd_o     = '0;
    case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          push = 1'b1;
          if (!last_word_i) begin
            len_d     = len_q + sh1_pkg::LenW'(sh1_pkg::FullBytes);
            push_word = data_word_i;
            after     = FIdle;
          end else begin
            len_d = len_q + sh1_pkg::LenW'(cnt_eff);
            if (cnt_eff == sh1_pkg::FullBytes) begin
              push_word = data_word_i;
              after     = FMark;
            end else begin
              push_word = sh1_pkg::pad_partial(data_word_i, cnt_eff[1:0]);
              after     = FPad;
            end
          end
        end
      end
      FMark: begin
        push      = 1'b1;
        push_word = sh1_pkg::PadMarker;
        after     = FPad;
      end
      FPad: begin
        push = 1'b1;
        if (fill_q == sh1_pkg::LenHiSlot) begin
          push_word = len_q[sh1_pkg::LenW-1:29];
          after     = FLenLo;
        end else begin
          push_word = '0;
          after     = FPad;
        end
      end
      FLenLo: begin
        push      = 1'b1;
        push_word = {len_q[28:0], 3'b000};
        after     = FOut;
      end
      FWait: begin
        if (core_done_i) state_d = ret_q;
      end
      FOut: begin
        if (!out_stall_i) begin
          if (idx_q == sh1_pkg::LastDigIdx) begin
            idx_d      = '0;
            fill_d     = '0;
            len_d      = '0;
            cmd_o.init = 1'b1;
            state_d    = FIdle;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = FIdle;
    endcase

    if (push) begin
      cmd_o.wr_en   = 1'b1;
      cmd_o.wr_addr = fill_q;
      cmd_o.wr_data = push_word;
      fill_d        = fill_q + 1'b1;
      if (fill_q == sh1_pkg::LastSlot) begin
        cmd_o.start = 1'b1;
        ret_d       = after;
        state_d     = FWait;
      end else begin
        state_d = after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      ret_q   <= FIdle;
      fill_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o  = (state_q != FIdle);
  assign out_valid_o = (state_q == FOut);
  assign out_idx_o   = idx_q;
  assign out_last_o  = (idx_q == sh1_pkg::LastDigIdx);

endmodule

/* hw/rtl/sha1_message_hasher_top.sv */
// SHA-1 message hasher, top level.
// Depends on sh1_pkg, sh1_feed and sh1_core.

// Takes one message as big-endian 32-bit words, each item with a count of
// valid leading bytes (counts above four read as four; a non-last item always
// counts as four bytes) and a last-word flag, and returns the 160-bit SHA-1
// digest as five output items, H0 first, digest_done_o high on the fifth.
// After the fifth item is taken the block is back in its reset state and
// takes the next message. A word that does not complete a 16-word block
// is taken without a stall. The word that completes a block starts a
// compression (load the working variables and issue the first schedule
// reads, 80 rounds at one round per cycle, add into the chaining values),
// during which in_stall_o stays high. The round loop is built around the
// message schedule memory: the schedule lives in a pair of 16-word
// memories with registered reads, expanded in place. The last word is
// followed by padding writes at one word per cycle outside compressions
// (the marker, zeros, the 64-bit bit length), one or two compressions, then
// the five digest items; no input is taken until the fifth digest item has
// been accepted.
module sha1_message_hasher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sh1_pkg::WordW-1:0]    data_word_i,
  input  logic [2:0]                   byte_count_i,
  input  logic                         last_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sh1_pkg::WordW-1:0]    digest_word_o,
  output logic [sh1_pkg::DigIdxW-1:0]  word_index_o,
  output logic                         digest_done_o
);

  sh1_pkg::core_cmd_t          cmd;
  logic                        core_done;
  sh1_pkg::digest_t            hash;
  logic [sh1_pkg::DigIdxW-1:0] out_idx;
  logic                        out_last;

  // packing, length count, padding and output sequencing
  sh1_feed u_feed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .core_done_i  (core_done),
    .cmd_o        (cmd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_idx_o    (out_idx),
    .out_last_o   (out_last)
  );

  // schedule memories, 80-round datapath, chaining values
  sh1_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .done_o (core_done),
    .hash_o (hash)
  );

  // chaining values hold steady while the digest items are handed out,
  // so the output word is a plain select on the index register
  assign digest_word_o = hash[out_idx];
  assign word_index_o  = out_idx;
  assign digest_done_o = out_last;

endmodule
